[rtl/ibst_pkg.sv]
// ibst_pkg: shared constants, types and control/status structs for the
// array-based binary search tree block. No dependencies.
package ibst_pkg;

  // tree geometry and key size
  localparam int TREE_LEVELS = 10;
  localparam int KEY_WIDTH   = 16;
  localparam int SLOT_COUNT  = 1 << TREE_LEVELS;

  // fixed widths of the result fields
  localparam int SLOT_OUT_WIDTH = 10;
  localparam int COUNT_WIDTH    = 10;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = COUNT_WIDTH'(1023);

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef logic [KEY_WIDTH-1:0]   key_t;
  typedef logic [TREE_LEVELS-1:0] pos_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  // one slot of the tree store
  typedef struct packed {
    logic valid;
    key_t key;
  } node_t;

  localparam int NODE_WIDTH = $bits(node_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic step;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic stop;
  } dpath_stat_t;

endpackage

[rtl/ibst_ram.sv]
// ibst_ram: generic single-port RAM with registered read data.
// No dependencies.
module ibst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and registered read of the addressed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/ibst_ctrl.sv]
// ibst_ctrl: sequencer for the clearing pass, request transfer and tree walk.
// Depends on ibst_pkg.
module ibst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ibst_pkg::dpath_stat_t stat,
  output ibst_pkg::ctrl_cmd_t   cmd,
  output logic                 busy
);

  ibst_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ibst_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ibst_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = ibst_pkg::ST_IDLE;
        end
      end
      ibst_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ibst_pkg::ST_WALK;
        end
      end
      ibst_pkg::ST_WALK: begin
        cmd.step = 1'b1;
        if (stat.stop) begin
          state_next = ibst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ibst_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

[rtl/ibst_dpath.sv]
// ibst_dpath: tree store, walk position, compare logic, entry count and
// result registers. Depends on ibst_pkg and ibst_ram.
module ibst_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  ibst_pkg::ctrl_cmd_t                cmd,
  input  logic                               req_type,
  input  logic [15:0]                        key,
  output ibst_pkg::dpath_stat_t              stat,
  output logic                               done,
  output logic [ibst_pkg::SLOT_OUT_WIDTH-1:0] slot_index,
  output logic                               found,
  output logic                               overflow,
  output ibst_pkg::count_t                   entry_count
);

  logic                         req_search;
  ibst_pkg::key_t               req_key;
  ibst_pkg::pos_t               pos;
  ibst_pkg::pos_t               clr_cnt;
  ibst_pkg::count_t             count;
  ibst_pkg::count_t             count_inc;
  ibst_pkg::node_t              node;
  ibst_pkg::pos_t               child;
  ibst_pkg::pos_t               ram_addr;
  logic                         ram_we;
  logic [ibst_pkg::NODE_WIDTH-1:0] ram_wdata;
  logic [ibst_pkg::NODE_WIDTH-1:0] ram_rdata;
  logic                         go_left;
  logic                         hit;
  logic                         empty;
  logic                         over;
  logic                         stop;
  logic                         do_write;
  logic                         finish;

  ibst_ram #(
    .WIDTH (ibst_pkg::NODE_WIDTH),
    .DEPTH (ibst_pkg::SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // compare the node read at the current position
  always_comb begin
    node    = ibst_pkg::node_t'(ram_rdata);
    empty   = !node.valid;
    hit     = req_search && node.valid && (node.key == req_key);
    go_left = req_search ? (req_key < node.key) : (req_key <= node.key);
    // descending below the deepest level
    over    = node.valid && !hit && pos[ibst_pkg::TREE_LEVELS-1];
    stop    = empty || hit || over;
    child   = {pos[ibst_pkg::TREE_LEVELS-2:0], !go_left};
    finish  = cmd.step && stop;
    do_write  = finish && empty && (req_search == ibst_pkg::REQ_INSERT);
    count_inc = (count < ibst_pkg::COUNT_MAX) ? count + 1'b1 : count;
  end

  // store address, write enable and write data
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (cmd.clear) begin
      ram_addr = clr_cnt;
      ram_we   = 1'b1;
    end else if (cmd.load) begin
      ram_addr = ibst_pkg::pos_t'(1);
    end else if (finish) begin
      ram_addr  = pos;
      ram_we    = do_write;
      ram_wdata = {1'b1, req_key};
    end else begin
      ram_addr = child;
    end
  end

  assign stat.clear_last = (clr_cnt == {ibst_pkg::TREE_LEVELS{1'b1}});
  assign stat.stop       = stop;

  // clearing pass counter, entry count and done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (do_write) begin
        count <= count_inc;
      end
      done <= finish;
    end
  end

  // request capture and walk position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_search <= req_type;
      req_key    <= ibst_pkg::key_t'(key);
      pos        <= ibst_pkg::pos_t'(1);
    end else if (cmd.step && !stop) begin
      pos <= child;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (finish) begin
      slot_index  <= over ? '0 : ibst_pkg::SLOT_OUT_WIDTH'(pos);
      found       <= hit;
      overflow    <= over;
      entry_count <= do_write ? count_inc : count;
    end
  end

endmodule

[rtl/implicit_array_bst_insert_search.sv]
// Binary search tree in one heap-indexed store (root at slot 1, children of
// slot i at 2i and 2i+1). After reset the block sweeps the store to clear
// every slot, one slot a cycle, all 2^TREE_LEVELS = 1024 slots, with busy high.
// A request transfers when start is high and busy is low. The walk then reads
// one tree level per cycle through the store's single port, down to the depth
// d (1 .. TREE_LEVELS) at which the request stops. The done strobe and the
// result are registered from the cycle in which the walk stops, and the
// result transfers at the edge that ends the cycle with done high. A new
// request may transfer at that same edge. Each result is shown for exactly
// one cycle with done high; the receiver cannot stall it.
// Depends on ibst_pkg, ibst_ctrl, ibst_dpath and ibst_ram.
module implicit_array_bst_insert_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic [15:0]                         key,
  output logic                                done,
  output logic [ibst_pkg::SLOT_OUT_WIDTH-1:0] slot_index,
  output logic                                found,
  output logic                                overflow,
  output logic [ibst_pkg::COUNT_WIDTH-1:0]    entry_count
);

  ibst_pkg::ctrl_cmd_t   cmd;
  ibst_pkg::dpath_stat_t stat;

  ibst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ibst_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req_type),
    .key         (key),
    .stat        (stat),
    .done        (done),
    .slot_index  (slot_index),
    .found       (found),
    .overflow    (overflow),
    .entry_count (entry_count)
  );

  // a result only appears once the walk has handed control back
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // overflow reports slot zero and never a hit
  a_over_slot: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (slot_index == '0 && !found))
    else $error("overflow result with nonzero slot or hit");

  // busy rises right after a request transfer
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  // on a result strobe the reported entry count never exceeds the internal count
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done, 1) == 1'b0 && $past(!rst, 1)) |->
      (u_dpath.count >= entry_count || entry_count == u_dpath.count))
    else $error("entry count mismatch");

endmodule
